[hdl/dfr_pkg.sv]
// Shared types and constants for the delimited frame receiver.
`timescale 1ns / 1ps

package dfr_pkg;

   // Reset values of the marker registers
   localparam logic [7:0] START_MARKER_RESET = 8'd97;
   localparam logic [7:0] END_MARKER_RESET   = 8'd101;

   // Width of the reported frame position
   localparam int unsigned INDEX_W = 5;

   // Configuration register indexes
   localparam logic CSR_START_MARKER = 1'b0;
   localparam logic CSR_END_MARKER   = 1'b1;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_CONTINUE = 2'd0,
      STATUS_VALID    = 2'd1,
      STATUS_ERROR    = 2'd2
   } status_type;

   // Commands from the front part to the back part
   typedef enum logic [1:0] {
      CMD_CONTINUE = 2'd0,
      CMD_ERROR    = 2'd1,
      CMD_COMMIT   = 2'd2
   } cmd_type;

   // Back part control states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } back_state_type;

endpackage

[hdl/dfr_cmd_queue.sv]
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps

module dfr_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  dfr_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output dfr_pkg::cmd_type head_cmd,
   output logic             empty
);

   dfr_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[hdl/dfr_front.sv]
// Front part: accepts bytes, tracks framing, fills the buffer, issues commands.
`timescale 1ns / 1ps

module dfr_front #(
   parameter int unsigned FRAME_BYTES = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   // byte input
   input  logic                           req_push,
   input  logic [7:0]                     req_rx_byte,
   output logic                           req_full,
   // configuration
   input  logic                           csr_we,
   input  logic                           csr_index,
   input  logic [7:0]                     csr_wdata,
   // command queue
   output logic                           cmd_push,
   output dfr_pkg::cmd_type               cmd_data,
   input  logic                           cmd_full,
   // frame buffer write port
   output logic                           buf_wr_en,
   output logic [$clog2(FRAME_BYTES)-1:0] buf_wr_addr,
   output logic [7:0]                     buf_wr_data,
   // readout of the committed frame has finished
   input  logic                           readout_done
);

   localparam int unsigned AW = $clog2(FRAME_BYTES);
   localparam int unsigned PW = $clog2(FRAME_BYTES + 1);

   logic [7:0]    start_marker_ff;
   logic [7:0]    end_marker_ff;
   logic          receiving_ff;
   logic          receiving_in;
   logic [PW-1:0] position_ff;
   logic [PW-1:0] position_in;
   logic          busy_ff;
   logic          busy_in;
   logic          in_payload;
   logic          accept;

   assign in_payload = receiving_ff && (position_ff < PW'(FRAME_BYTES));

   // Hold payload bytes while the buffer still holds a frame being read out
   assign req_full = cmd_full || (in_payload && busy_ff);
   assign accept   = req_push && !req_full;

   assign buf_wr_en   = accept && in_payload;
   assign buf_wr_addr = position_ff[AW-1:0];
   assign buf_wr_data = req_rx_byte;

   // Classify the byte and advance the framing state
   always_comb begin
      receiving_in = receiving_ff;
      position_in  = position_ff;
      busy_in      = busy_ff;
      cmd_data     = dfr_pkg::CMD_CONTINUE;
      if (readout_done) begin
         busy_in = 1'b0;
      end
      if (!receiving_ff) begin
         if (accept && (req_rx_byte == start_marker_ff)) begin
            receiving_in = 1'b1;
            position_in  = '0;
         end
      end else if (in_payload) begin
         if (accept) begin
            position_in = position_ff + PW'(1);
         end
      end else begin
         if (req_rx_byte == end_marker_ff) begin
            cmd_data = dfr_pkg::CMD_COMMIT;
         end else begin
            cmd_data = dfr_pkg::CMD_ERROR;
         end
         if (accept) begin
            receiving_in = 1'b0;
            position_in  = '0;
            if (req_rx_byte == end_marker_ff) begin
               busy_in = 1'b1;
            end
         end
      end
   end

   assign cmd_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff <= 1'b0;
         position_ff  <= '0;
         busy_ff      <= 1'b0;
      end else begin
         receiving_ff <= receiving_in;
         position_ff  <= position_in;
         busy_ff      <= busy_in;
      end
   end

   // Marker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= dfr_pkg::START_MARKER_RESET;
         end_marker_ff   <= dfr_pkg::END_MARKER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            dfr_pkg::CSR_START_MARKER: start_marker_ff <= csr_wdata;
            dfr_pkg::CSR_END_MARKER:   end_marker_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

endmodule

[hdl/dfr_back.sv]
// Back part: executes commands, holds the frame buffer, drives the result register.
`timescale 1ns / 1ps

module dfr_back #(
   parameter int unsigned FRAME_BYTES = 25
) (
   input  logic                              clock,
   input  logic                              reset,
   // command queue
   input  logic                              cmd_empty,
   input  dfr_pkg::cmd_type                  cmd_head,
   output logic                              cmd_pop,
   // frame buffer write port
   input  logic                              buf_wr_en,
   input  logic [$clog2(FRAME_BYTES)-1:0]    buf_wr_addr,
   input  logic [7:0]                        buf_wr_data,
   output logic                              readout_done,
   // results
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_has_data,
   output logic [7:0]                        rsp_data_byte,
   output logic [dfr_pkg::INDEX_W-1:0]       rsp_byte_index,
   output logic                              rsp_last
);

   localparam int unsigned AW = $clog2(FRAME_BYTES);
   localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 1);

   logic [7:0]                    buffer_mem [FRAME_BYTES];
   dfr_pkg::back_state_type       state_ff;
   dfr_pkg::back_state_type       state_in;
   logic [AW-1:0]                 rd_idx_ff;
   logic [AW-1:0]                 rd_idx_in;
   logic [7:0]                    rd_data_ff;
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic [AW-1:0]                 s1_idx_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   dfr_pkg::status_type           out_status_ff;
   logic                          out_has_data_ff;
   logic [7:0]                    out_data_ff;
   logic [dfr_pkg::INDEX_W-1:0]   out_index_ff;
   logic                          out_last_ff;
   logic                          adv_out;
   logic                          s1_load;
   logic                          take_simple;
   logic                          take_commit;

   assign adv_out     = !out_valid_ff || rsp_pop;
   assign s1_load     = (state_ff == dfr_pkg::ST_READ) && (!s1_valid_ff || adv_out);
   assign take_simple = (state_ff == dfr_pkg::ST_IDLE) && !cmd_empty
                        && (cmd_head != dfr_pkg::CMD_COMMIT) && !s1_valid_ff && adv_out;
   assign take_commit = (state_ff == dfr_pkg::ST_IDLE) && !cmd_empty
                        && (cmd_head == dfr_pkg::CMD_COMMIT);
   assign cmd_pop      = take_simple || take_commit;
   assign readout_done = s1_load && (rd_idx_ff == LAST_IDX);

   // Sequence the readout of a committed frame
   always_comb begin
      state_in  = state_ff;
      rd_idx_in = rd_idx_ff;
      unique case (state_ff)
         dfr_pkg::ST_IDLE: begin
            if (take_commit) begin
               state_in  = dfr_pkg::ST_READ;
               rd_idx_in = '0;
            end
         end
         dfr_pkg::ST_READ: begin
            if (s1_load) begin
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = dfr_pkg::ST_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = dfr_pkg::ST_IDLE;
         end
      endcase
   end

   // Read stage valid: load on a read, drain into the result register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
      end else if (adv_out) begin
         s1_valid_in = 1'b0;
      end
   end

   // Result register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if ((s1_valid_ff && adv_out) || take_simple) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfr_pkg::ST_IDLE;
         rd_idx_ff    <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_idx_ff    <= rd_idx_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Frame buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (buf_wr_en) begin
         buffer_mem[buf_wr_addr] <= buf_wr_data;
      end
      if (s1_load) begin
         rd_data_ff <= buffer_mem[rd_idx_ff];
         s1_idx_ff  <= rd_idx_ff;
      end
   end

   // Load the result register from the read stage or from a simple command
   always_ff @(posedge clock) begin
      if (s1_valid_ff && adv_out) begin
         out_status_ff   <= dfr_pkg::STATUS_VALID;
         out_has_data_ff <= 1'b1;
         out_data_ff     <= rd_data_ff;
         out_index_ff    <= dfr_pkg::INDEX_W'(s1_idx_ff);
         out_last_ff     <= (s1_idx_ff == LAST_IDX);
      end else if (take_simple) begin
         out_status_ff   <= (cmd_head == dfr_pkg::CMD_ERROR) ?
                            dfr_pkg::STATUS_ERROR : dfr_pkg::STATUS_CONTINUE;
         out_has_data_ff <= 1'b0;
         out_data_ff     <= 8'd0;
         out_index_ff    <= '0;
         out_last_ff     <= 1'b1;
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_has_data   = out_has_data_ff;
   assign rsp_data_byte  = out_data_ff;
   assign rsp_byte_index = out_index_ff;
   assign rsp_last       = out_last_ff;

endmodule

[hdl/delimited_frame_receiver.sv]
// Top level of the start/end delimited frame receiver.
`timescale 1ns / 1ps

// Usage:
//   Input queue: drive req_rx_byte and req_push; a byte transfers at a clock edge
//   with req_push high and req_full low. Result queue: while rsp_empty is low the
//   oldest result sits on the rsp_ ports; it transfers at an edge with rsp_pop high.
//   Marker registers are written through csr_we / csr_index / csr_wdata
//   (index 0 start marker, index 1 end marker) while the block is idle.
//   Every byte yields one result, except a correctly closed frame, whose closing
//   byte yields FRAME_BYTES results (payload byte 0 first, last one marked).
//   A single result passes from the command queue into the result register; a frame
//   readout passes from the command queue through the buffer read stage into it.
//   Throughput: one byte per cycle while req_full is low. The readout walks the frame
//   buffer one entry per cycle over its single read port unless rsp_pop holds it back;
//   payload bytes of the next frame are held off (req_full high) until that walk is done.
//   Reset clears framing state, the command queue and the result register, and
//   restores the markers to 'a' and 'e'; the buffer needs no clearing.
//   When the receiver stalls (rsp_pop low) results back up into the command
//   queue, and req_full rises once that two-entry queue is full.

module delimited_frame_receiver #(
   parameter int unsigned FRAME_BYTES = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  logic [7:0]                  req_rx_byte,
   output logic                        req_full,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [1:0]                  rsp_status,
   output logic                        rsp_has_data,
   output logic [7:0]                  rsp_data_byte,
   output logic [dfr_pkg::INDEX_W-1:0] rsp_byte_index,
   output logic                        rsp_last,
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [7:0]                  csr_wdata
);

   localparam int unsigned AW = $clog2(FRAME_BYTES);

   logic             cmd_push;
   dfr_pkg::cmd_type cmd_data;
   logic             cmd_full;
   logic             cmd_pop;
   dfr_pkg::cmd_type cmd_head;
   logic             cmd_empty;
   logic             buf_wr_en;
   logic [AW-1:0]    buf_wr_addr;
   logic [7:0]       buf_wr_data;
   logic             readout_done;

   dfr_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_rx_byte  (req_rx_byte),
      .req_full     (req_full),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_data),
      .cmd_full     (cmd_full),
      .buf_wr_en    (buf_wr_en),
      .buf_wr_addr  (buf_wr_addr),
      .buf_wr_data  (buf_wr_data),
      .readout_done (readout_done)
   );

   dfr_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd_data),
      .full     (cmd_full),
      .pop      (cmd_pop),
      .head_cmd (cmd_head),
      .empty    (cmd_empty)
   );

   dfr_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_empty      (cmd_empty),
      .cmd_head       (cmd_head),
      .cmd_pop        (cmd_pop),
      .buf_wr_en      (buf_wr_en),
      .buf_wr_addr    (buf_wr_addr),
      .buf_wr_data    (buf_wr_data),
      .readout_done   (readout_done),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_status     (rsp_status),
      .rsp_has_data   (rsp_has_data),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_last       (rsp_last)
   );

endmodule

[bench/delimited_frame_receiver_tb.sv]
// Testbench for the delimited frame receiver: directed and random framed byte traffic checked by a predictor.
`timescale 1ns / 1ps

module delimited_frame_receiver_tb;

   localparam int unsigned FRAME_BYTES   = 25;
   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned CYCLE_LIMIT   = 300000;
   localparam int unsigned MAX_PRINTS    = 40;

   // One transfer on the result side
   typedef struct packed {
      dfr_pkg::status_type         status;
      logic                        has_data;
      logic [7:0]                  data_byte;
      logic [dfr_pkg::INDEX_W-1:0] byte_index;
      logic                        last;
   } frame_result_type;

   // Predicts the results of each accepted byte and checks the results that come out
   class frame_scoreboard;
      logic [7:0]       start_mark;
      logic [7:0]       end_mark;
      bit               in_frame;
      int unsigned      fill_count;
      logic [7:0]       payload [FRAME_BYTES];
      frame_result_type expected_q [$];
      int unsigned      error_count;
      int unsigned      byte_count;
      int unsigned      result_count;
      int unsigned      commit_count;
      int unsigned      reject_count;

      function new();
         start_mark   = dfr_pkg::START_MARKER_RESET;
         end_mark     = dfr_pkg::END_MARKER_RESET;
         in_frame     = 1'b0;
         fill_count   = 0;
         error_count  = 0;
         byte_count   = 0;
         result_count = 0;
         commit_count = 0;
         reject_count = 0;
      endfunction

      task report(string msg);
         error_count++;
         if (error_count <= MAX_PRINTS)
            $display("MISMATCH at %0t ns: %s", $time, msg);
      endtask

      function void set_marker(logic index, logic [7:0] value);
         if (index == dfr_pkg::CSR_START_MARKER)
            start_mark = value;
         else
            end_mark = value;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // Advance the framing state by one accepted byte and queue its results
      function void note_input(logic [7:0] value);
         frame_result_type r;
         byte_count++;
         r.status     = dfr_pkg::STATUS_CONTINUE;
         r.has_data   = 1'b0;
         r.data_byte  = 8'h00;
         r.byte_index = '0;
         r.last       = 1'b1;
         if (!in_frame) begin
            if (value == start_mark) begin
               in_frame   = 1'b1;
               fill_count = 0;
            end
            expected_q.push_back(r);
         end else if (fill_count < FRAME_BYTES) begin
            payload[fill_count] = value;
            fill_count++;
            expected_q.push_back(r);
         end else begin
            in_frame   = 1'b0;
            fill_count = 0;
            if (value != end_mark) begin
               r.status = dfr_pkg::STATUS_ERROR;
               expected_q.push_back(r);
               reject_count++;
            end else begin
               for (int i = 0; i < FRAME_BYTES; i++) begin
                  r.status     = dfr_pkg::STATUS_VALID;
                  r.has_data   = 1'b1;
                  r.data_byte  = payload[i];
                  r.byte_index = dfr_pkg::INDEX_W'(i);
                  r.last       = (i == FRAME_BYTES - 1);
                  expected_q.push_back(r);
               end
               commit_count++;
            end
         end
      endfunction

      // Compare one result transfer against the oldest expectation
      task check_result(frame_result_type got);
         frame_result_type want;
         result_count++;
         if (expected_q.size() == 0) begin
            report($sformatf("result with nothing expected (status %0d)", got.status));
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status)
            report($sformatf("status got %0d expected %0d", got.status, want.status));
         if (got.has_data !== want.has_data)
            report($sformatf("has_data got %0b expected %0b", got.has_data, want.has_data));
         if (got.data_byte !== want.data_byte)
            report($sformatf("data_byte got %02h expected %02h", got.data_byte,
                             want.data_byte));
         if (got.byte_index !== want.byte_index)
            report($sformatf("byte_index got %0d expected %0d", got.byte_index,
                             want.byte_index));
         if (got.last !== want.last)
            report($sformatf("last got %0b expected %0b", got.last, want.last));
      endtask
   endclass

   logic                        clock       = 1'b0;
   logic                        reset       = 1'b1;
   logic                        req_push    = 1'b0;
   logic [7:0]                  req_rx_byte = 8'h00;
   logic                        req_full;
   logic                        rsp_empty;
   logic                        rsp_pop     = 1'b0;
   logic [1:0]                  rsp_status;
   logic                        rsp_has_data;
   logic [7:0]                  rsp_data_byte;
   logic [dfr_pkg::INDEX_W-1:0] rsp_byte_index;
   logic                        rsp_last;
   logic                        csr_we      = 1'b0;
   logic                        csr_index   = dfr_pkg::CSR_START_MARKER;
   logic [7:0]                  csr_wdata   = 8'h00;

   frame_scoreboard sb = new();

   // Sender pacing and receiver stall state
   bit          paced        = 1'b1;
   int unsigned burst_left   = 0;
   bit          hold_request = 1'b0;
   int unsigned hold_left    = 0;
   int unsigned pop_mode     = 0;
   int unsigned mode_left    = 0;
   logic [7:0]  stall_mask   = 8'hFF;
   int unsigned cycle_count  = 0;

   delimited_frame_receiver #(
      .FRAME_BYTES(FRAME_BYTES)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_rx_byte   (req_rx_byte),
      .req_full      (req_full),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_status    (rsp_status),
      .rsp_has_data  (rsp_has_data),
      .rsp_data_byte (rsp_data_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #6 clock = ~clock;

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Cycle limit reached with %0d results outstanding", sb.pending());
         $display("Verification failed");
         $finish;
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      frame_result_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.status     = dfr_pkg::status_type'(rsp_status);
         got.has_data   = rsp_has_data;
         got.data_byte  = rsp_data_byte;
         got.byte_index = rsp_byte_index;
         got.last       = rsp_last;
         sb.check_result(got);
      end
   end

   // Drive pop: rotate through stall patterns, hold off completely on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
         pop_mode   = $urandom_range(0, 3);
         mode_left  = $urandom_range(16, 96);
         stall_mask = 8'($urandom) | 8'h01;
      end else begin
         mode_left--;
      end
      stall_mask = {stall_mask[6:0], stall_mask[7]};
      if (hold_left != 0) begin
         hold_left--;
         rsp_pop <= 1'b0;
      end else begin
         case (pop_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= 1'($urandom_range(0, 1));
            2: rsp_pop <= stall_mask[0];
            default: rsp_pop <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Offer one byte and hold it until it transfers; entered and left at a falling edge
   task automatic send_byte(input logic [7:0] value);
      int unsigned gap;
      if (paced && burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 12);
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (burst_left != 0)
         burst_left--;
      req_rx_byte <= value;
      req_push    <= 1'b1;
      do @(posedge clock); while (req_full);
      sb.note_input(value);
      @(negedge clock);
   endtask

   // Drop push and wait until every expected result has come out
   task automatic wait_idle();
      req_push <= 1'b0;
      while (sb.pending() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_marker(input logic index, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      sb.set_marker(index, value);
      @(negedge clock);
   endtask

   // Payload byte biased toward the markers and the extremes
   function automatic logic [7:0] pick_payload();
      case ($urandom_range(0, 15))
         0: return sb.start_mark;
         1: return sb.end_mark;
         2: return 8'h00;
         3: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Feed bytes until the framing state is back to idle
   task automatic finish_frame();
      while (sb.in_frame)
         send_byte(pick_payload());
   endtask

   task automatic send_frame(input bit good_close);
      logic [7:0] closing;
      finish_frame();
      send_byte(sb.start_mark);
      repeat (FRAME_BYTES) send_byte(pick_payload());
      if (good_close) begin
         closing = sb.end_mark;
      end else begin
         do closing = 8'($urandom_range(0, 255)); while (closing == sb.end_mark);
      end
      send_byte(closing);
   endtask

   // Mostly well-formed frames, some broken ones and some line noise
   task automatic run_traffic(input int unsigned count);
      int unsigned target;
      int unsigned pick;
      target = sb.byte_count + count;
      while (sb.byte_count < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 13)
            send_frame(1'b1);
         else if (pick < 16)
            send_frame(1'b0);
         else
            repeat ($urandom_range(1, 4)) send_byte(pick_payload());
      end
      finish_frame();
   endtask

   initial begin
      int unsigned settings;
      settings = 1;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: idle bytes, then a frame carrying extremes and both markers
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(dfr_pkg::END_MARKER_RESET);
      send_byte(dfr_pkg::START_MARKER_RESET);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(dfr_pkg::START_MARKER_RESET);
      send_byte(dfr_pkg::END_MARKER_RESET);
      for (int i = 4; i < FRAME_BYTES; i++)
         send_byte(8'(i * 37 + 5));
      send_byte(dfr_pkg::END_MARKER_RESET);
      wait_idle();

      // Extreme markers; stall the receiver while the sender streams
      write_marker(dfr_pkg::CSR_START_MARKER, 8'h00);
      write_marker(dfr_pkg::CSR_END_MARKER, 8'hFF);
      settings++;
      paced        = 1'b0;
      hold_request = 1'b1;
      run_traffic(90);
      paced = 1'b1;
      wait_idle();

      write_marker(dfr_pkg::CSR_START_MARKER, 8'hFF);
      write_marker(dfr_pkg::CSR_END_MARKER, 8'h00);
      settings++;
      run_traffic(90);
      wait_idle();

      // Same value opens and closes a frame
      write_marker(dfr_pkg::CSR_START_MARKER, 8'h3C);
      write_marker(dfr_pkg::CSR_END_MARKER, 8'h3C);
      settings++;
      run_traffic(80);
      wait_idle();

      write_marker(dfr_pkg::CSR_START_MARKER, 8'($urandom_range(0, 255)));
      write_marker(dfr_pkg::CSR_END_MARKER, 8'($urandom_range(0, 255)));
      settings++;
      run_traffic(90);
      wait_idle();

      write_marker(dfr_pkg::CSR_START_MARKER, dfr_pkg::START_MARKER_RESET);
      write_marker(dfr_pkg::CSR_END_MARKER, dfr_pkg::END_MARKER_RESET);
      settings++;
      run_traffic(90);
      wait_idle();

      $display("Sent %0d bytes under %0d marker settings, checked %0d results",
               sb.byte_count, settings, sb.result_count);
      $display("Frames committed: %0d, frames rejected: %0d, mismatches: %0d",
               sb.commit_count, sb.reject_count, sb.error_count);
      if (sb.error_count == 0 && sb.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
